// ===== rtl/core/spa_pkg.sv =====
`timescale 1ns / 1ps

package spa_pkg;

  // Widths of the segment fields and of the internal coordinate.
  localparam int OP_WIDTH    = 8;
  localparam int ARG_WIDTH   = 32;
  localparam int NUM_ARGS    = 7;
  localparam int COORD_WIDTH = 32;

  // Signed coordinate range, held in 64 bits so that every width up to 64 fits.
  localparam longint COORD_MAX = longint'((65'd1 << (COORD_WIDTH - 1)) - 65'd1);
  localparam longint COORD_MIN = -COORD_MAX - 64'sd1;

  typedef logic [OP_WIDTH-1:0]           op_t;
  typedef logic signed [ARG_WIDTH-1:0]   arg_t;
  typedef logic signed [COORD_WIDTH-1:0] coord_t;

  // Command letters.
  localparam op_t CHAR_A     = 8'h41;
  localparam op_t CHAR_C     = 8'h43;
  localparam op_t CHAR_H     = 8'h48;
  localparam op_t CHAR_L     = 8'h4C;
  localparam op_t CHAR_M     = 8'h4D;
  localparam op_t CHAR_Q     = 8'h51;
  localparam op_t CHAR_S     = 8'h53;
  localparam op_t CHAR_T     = 8'h54;
  localparam op_t CHAR_V     = 8'h56;
  localparam op_t CHAR_Z     = 8'h5A;
  localparam op_t CHAR_LOW_A = 8'h61;
  localparam op_t CHAR_LOW_Z = 8'h7A;
  localparam op_t CASE_STEP  = 8'h20;

  // Segment classes as seen by the execution side.
  typedef enum logic [2:0] {
    KIND_MOVE,
    KIND_PAIRS,
    KIND_ARC,
    KIND_HORIZ,
    KIND_VERT,
    KIND_CLOSE
  } kind_e;

  // One decoded segment waiting in the queue.
  typedef struct packed {
    op_t                       up_op;
    logic                      rel;
    kind_e                     kind;
    logic [1:0]                npairs;
    arg_t [NUM_ARGS-1:0]       args;
  } seg_t;

  // Clamp an operand to the coordinate range.
  function automatic coord_t clamp_arg(arg_t a);
    longint w;
    w = longint'(a);
    if (w > COORD_MAX) begin
      return COORD_WIDTH'(COORD_MAX);
    end else if (w < COORD_MIN) begin
      return COORD_WIDTH'(COORD_MIN);
    end
    return COORD_WIDTH'(w);
  endfunction

  // Saturating add in the coordinate range.
  function automatic coord_t sat_add(coord_t a, coord_t b);
    logic signed [COORD_WIDTH:0] s;
    s = (COORD_WIDTH + 1)'(a) + (COORD_WIDTH + 1)'(b);
    if (s[COORD_WIDTH] != s[COORD_WIDTH-1]) begin
      return s[COORD_WIDTH] ? COORD_WIDTH'(COORD_MIN) : COORD_WIDTH'(COORD_MAX);
    end
    return s[COORD_WIDTH-1:0];
  endfunction

  // Low operand bits of a coordinate, sign extended first when it is narrow.
  function automatic arg_t to_arg(coord_t v);
    logic signed [63:0] w;
    w = 64'(v);
    return w[ARG_WIDTH-1:0];
  endfunction

endpackage

// ===== rtl/core/spa_seg_if.sv =====
`timescale 1ns / 1ps

// Input channel: one path segment per item.
interface spa_seg_if;
  logic          valid;
  logic          ready;
  spa_pkg::op_t  op;
  spa_pkg::arg_t arg0;
  spa_pkg::arg_t arg1;
  spa_pkg::arg_t arg2;
  spa_pkg::arg_t arg3;
  spa_pkg::arg_t arg4;
  spa_pkg::arg_t arg5;
  spa_pkg::arg_t arg6;

  modport source (output valid, op, arg0, arg1, arg2, arg3, arg4, arg5, arg6, input ready);
  modport sink   (input valid, op, arg0, arg1, arg2, arg3, arg4, arg5, arg6, output ready);
endinterface

// ===== rtl/core/spa_abs_if.sv =====
`timescale 1ns / 1ps

// Output channel: one absolute segment per item.
interface spa_abs_if;
  logic          valid;
  logic          ready;
  spa_pkg::op_t  abs_op;
  spa_pkg::arg_t res0;
  spa_pkg::arg_t res1;
  spa_pkg::arg_t res2;
  spa_pkg::arg_t res3;
  spa_pkg::arg_t res4;
  spa_pkg::arg_t res5;
  spa_pkg::arg_t res6;

  modport source (output valid, abs_op, res0, res1, res2, res3, res4, res5, res6,
                  input ready);
  modport sink   (input valid, abs_op, res0, res1, res2, res3, res4, res5, res6,
                  output ready);
endinterface

// ===== rtl/core/spa_front.sv =====
`timescale 1ns / 1ps

module spa_front (
  spa_seg_if.sink          seg_i,
  input  logic             q_full_i,
  output logic             push_o,
  output spa_pkg::seg_t    push_seg_o
);

  spa_pkg::op_t up;
  logic         rel;
  logic         known;

  // Take items whenever the queue has room; unknown letters are dropped here.
  assign seg_i.ready = !q_full_i;
  assign push_o      = seg_i.valid && !q_full_i && known;

  // Fold lower case to upper case and classify the command.
  always_comb begin
    rel = (seg_i.op >= spa_pkg::CHAR_LOW_A) && (seg_i.op <= spa_pkg::CHAR_LOW_Z);
    up  = rel ? (seg_i.op - spa_pkg::CASE_STEP) : seg_i.op;

    known             = 1'b1;
    push_seg_o.up_op  = up;
    push_seg_o.rel    = rel;
    push_seg_o.kind   = spa_pkg::KIND_PAIRS;
    push_seg_o.npairs = 2'd1;
    push_seg_o.args   = {seg_i.arg6, seg_i.arg5, seg_i.arg4, seg_i.arg3,
                         seg_i.arg2, seg_i.arg1, seg_i.arg0};

    case (up)
      spa_pkg::CHAR_M: begin
        push_seg_o.kind = spa_pkg::KIND_MOVE;
      end
      spa_pkg::CHAR_L, spa_pkg::CHAR_T: begin
        push_seg_o.kind = spa_pkg::KIND_PAIRS;
      end
      spa_pkg::CHAR_Q, spa_pkg::CHAR_S: begin
        push_seg_o.npairs = 2'd2;
      end
      spa_pkg::CHAR_C: begin
        push_seg_o.npairs = 2'd3;
      end
      spa_pkg::CHAR_A: begin
        push_seg_o.kind = spa_pkg::KIND_ARC;
      end
      spa_pkg::CHAR_H: begin
        push_seg_o.kind = spa_pkg::KIND_HORIZ;
      end
      spa_pkg::CHAR_V: begin
        push_seg_o.kind = spa_pkg::KIND_VERT;
      end
      spa_pkg::CHAR_Z: begin
        push_seg_o.kind = spa_pkg::KIND_CLOSE;
      end
      default: begin
        known = 1'b0;
      end
    endcase
  end

endmodule

// ===== rtl/core/spa_queue.sv =====
`timescale 1ns / 1ps

module spa_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  spa_pkg::seg_t push_seg_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic          empty_o,
  output spa_pkg::seg_t pop_seg_o
);

  spa_pkg::seg_t mem_q [2];
  logic          wr_ptr_q, wr_ptr_d;
  logic          rd_ptr_q, rd_ptr_d;
  logic [1:0]    count_q, count_d;

  assign full_o    = (count_q == 2'd2);
  assign empty_o   = (count_q == 2'd0);
  assign pop_seg_o = mem_q[rd_ptr_q];

  // Pointer and fill count update.
  always_comb begin
    wr_ptr_d = push_i ? !wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop_i ? !rd_ptr_q : rd_ptr_q;
    count_d  = count_q;
    if (push_i && !pop_i) begin
      count_d = count_q + 2'd1;
    end else if (!push_i && pop_i) begin
      count_d = count_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Entry storage.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_seg_i;
    end
  end

endmodule

// ===== rtl/core/spa_back.sv =====
`timescale 1ns / 1ps

module spa_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            q_empty_i,
  input  spa_pkg::seg_t   q_seg_i,
  output logic            pop_o,
  spa_abs_if.source       abs_o
);

  spa_pkg::coord_t pen_x_q, pen_x_d;
  spa_pkg::coord_t pen_y_q, pen_y_d;
  spa_pkg::coord_t sub_x_q, sub_x_d;
  spa_pkg::coord_t sub_y_q, sub_y_d;

  spa_pkg::coord_t a   [spa_pkg::NUM_ARGS];
  spa_pkg::coord_t r   [spa_pkg::NUM_ARGS];

  logic                                 out_valid_q;
  spa_pkg::op_t                         out_op_q;
  spa_pkg::arg_t [spa_pkg::NUM_ARGS-1:0] out_res_q, out_res_d;

  // Execute the head entry whenever the output register is free or being drained.
  assign pop_o = !q_empty_i && (!out_valid_q || abs_o.ready);

  // Offset operands by the current point and work out the new pen.
  always_comb begin
    spa_pkg::coord_t base;
    spa_pkg::coord_t sum;
    logic            used;
    logic            offset;

    for (int i = 0; i < spa_pkg::NUM_ARGS; i++) begin
      a[i]   = spa_pkg::clamp_arg(q_seg_i.args[i]);
      base   = ((i % 2) == 1) ? pen_y_q : pen_x_q;
      used   = 1'b0;
      offset = q_seg_i.rel;
      case (q_seg_i.kind)
        spa_pkg::KIND_MOVE, spa_pkg::KIND_PAIRS: begin
          used = (i < 2 * int'(q_seg_i.npairs));
        end
        spa_pkg::KIND_ARC: begin
          used   = 1'b1;
          offset = q_seg_i.rel && (i >= 5);
          base   = (i == 5) ? pen_x_q : pen_y_q;
        end
        spa_pkg::KIND_HORIZ: begin
          used = (i == 0);
          base = pen_x_q;
        end
        spa_pkg::KIND_VERT: begin
          used = (i == 0);
          base = pen_y_q;
        end
        default: begin
          used = 1'b0;
        end
      endcase
      sum  = spa_pkg::sat_add(a[i], base);
      r[i] = !used ? '0 : (offset ? sum : a[i]);
    end

    pen_x_d = pen_x_q;
    pen_y_d = pen_y_q;
    sub_x_d = sub_x_q;
    sub_y_d = sub_y_q;
    case (q_seg_i.kind)
      spa_pkg::KIND_MOVE, spa_pkg::KIND_PAIRS: begin
        case (q_seg_i.npairs)
          2'd2: begin
            pen_x_d = r[2];
            pen_y_d = r[3];
          end
          2'd3: begin
            pen_x_d = r[4];
            pen_y_d = r[5];
          end
          default: begin
            pen_x_d = r[0];
            pen_y_d = r[1];
          end
        endcase
        if (q_seg_i.kind == spa_pkg::KIND_MOVE) begin
          sub_x_d = pen_x_d;
          sub_y_d = pen_y_d;
        end
      end
      spa_pkg::KIND_ARC: begin
        pen_x_d = r[5];
        pen_y_d = r[6];
      end
      spa_pkg::KIND_HORIZ: begin
        pen_x_d = r[0];
      end
      spa_pkg::KIND_VERT: begin
        pen_y_d = r[0];
      end
      default: begin
        pen_x_d = sub_x_q;
        pen_y_d = sub_y_q;
      end
    endcase

    for (int i = 0; i < spa_pkg::NUM_ARGS; i++) begin
      out_res_d[i] = spa_pkg::to_arg(r[i]);
    end
  end

  // Current point, subpath start and output valid.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pen_x_q     <= '0;
      pen_y_q     <= '0;
      sub_x_q     <= '0;
      sub_y_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (pop_o) begin
        pen_x_q <= pen_x_d;
        pen_y_q <= pen_y_d;
        sub_x_q <= sub_x_d;
        sub_y_q <= sub_y_d;
      end
      if (pop_o) begin
        out_valid_q <= 1'b1;
      end else if (abs_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Output payload register.
  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      out_op_q  <= q_seg_i.up_op;
      out_res_q <= out_res_d;
    end
  end

  assign abs_o.valid  = out_valid_q;
  assign abs_o.abs_op = out_op_q;
  assign abs_o.res0   = out_res_q[0];
  assign abs_o.res1   = out_res_q[1];
  assign abs_o.res2   = out_res_q[2];
  assign abs_o.res3   = out_res_q[3];
  assign abs_o.res4   = out_res_q[4];
  assign abs_o.res5   = out_res_q[5];
  assign abs_o.res6   = out_res_q[6];

endmodule

// ===== rtl/core/svg_path_absolutizer.sv =====
`timescale 1ns / 1ps

// Channel  Direction  Payload                       Handshake
// seg_i    in         op, arg0..arg6                seg_i.valid / seg_i.ready
// abs_o    out        abs_op, res0..res6            abs_o.valid / abs_o.ready
//
// One segment per cycle sustained while abs_o.ready stays high; a result is
// held in the queue and then in the output register after its segment is taken.
// The current point updates in the execution stage, which sets the rate.
// Reset clears the current point, the subpath start, the queue and the output.
// Input and output stall on their own through a two-entry queue.

module svg_path_absolutizer (
  input  logic       clk_i,
  input  logic       rst_ni,
  spa_seg_if.sink    seg_i,
  spa_abs_if.source  abs_o
);

  logic          push;
  logic          pop;
  logic          q_full;
  logic          q_empty;
  spa_pkg::seg_t push_seg;
  spa_pkg::seg_t head_seg;

  spa_front u_front (
    .seg_i      (seg_i),
    .q_full_i   (q_full),
    .push_o     (push),
    .push_seg_o (push_seg)
  );

  spa_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_seg_i (push_seg),
    .full_o     (q_full),
    .pop_i      (pop),
    .empty_o    (q_empty),
    .pop_seg_o  (head_seg)
  );

  spa_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_empty_i (q_empty),
    .q_seg_i   (head_seg),
    .pop_o     (pop),
    .abs_o     (abs_o)
  );

endmodule
